// ----- rtl/core/rfb_pkg.sv -----
// rfb_pkg: shared types and constants for the ring FIFO burst block.
// Beat payload structs, operation codes, register map, controller links.
// No dependencies.
`default_nettype none

package rfb_pkg;

  localparam int RFB_DEPTH_LOG2 = 10;
  localparam int RFB_MAX_BURST  = 64;

  localparam int ELEM_W = 8;
  localparam int REQ_W  = 7;
  localparam int CNT_W  = 11;
  localparam int CAP_W  = 5;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_RESET = 2'd3;

  // register index (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [1:0]       operation;
    logic [ELEM_W-1:0] write_data;
    logic             write_last;
    logic [REQ_W-1:0] request_count;
  } in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] read_data;
    logic              data_valid;
    logic              last;
    logic              write_accepted;
    logic [CNT_W-1:0]  transfer_count;
    logic [CNT_W-1:0]  fill_level;
    logic              is_empty;
    logic              is_full;
  } out_t;

  typedef struct packed {
    logic load;   // latch the incoming beat
    logic exec;   // decode and run write / reset / read setup
    logic step;   // issue one element read
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       n_zero;     // read/peek has nothing to deliver
    logic       step_last;  // current step is the final element
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/rfb_ram.sv -----
// rfb_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module rfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rfb_ctrl.sv -----
// rfb_ctrl: sequencing state machine for the ring FIFO burst block.
// Depends on rfb_pkg (cmd_t, stat_t, operation codes).
`default_nettype none

module rfb_ctrl
  import rfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output      logic  busy,
  output      cmd_t  cmd,
  input  wire stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_STREAM = 3'b100
  } state_t;

  state_t state, state_next;
  logic   is_xfer;

  assign is_xfer = (stat.op == OP_READ) || (stat.op == OP_PEEK);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = (is_xfer && !stat.n_zero) ? ST_STREAM : ST_IDLE;
      end
      ST_STREAM: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/rfb_dp.sv -----
// rfb_dp: pointers, element store, clamping arithmetic and result register.
// Depends on rfb_pkg and rfb_ram.
`default_nettype none

module rfb_dp
  import rfb_pkg::*;
#(
  parameter int DEPTH_LOG2 = RFB_DEPTH_LOG2,
  parameter int MAX_BURST  = RFB_MAX_BURST
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output      stat_t            stat,
  input  wire in_t              item_in,
  input  wire logic             cfg_clr,
  input  wire logic [CAP_W-1:0] cap_log2,
  output      logic             strobe,
  output      out_t             result
);

  localparam int AW = DEPTH_LOG2;
  localparam int PW = DEPTH_LOG2 + 1;
  localparam int CW = (PW > REQ_W) ? PW : REQ_W;

  in_t              item;
  logic [PW-1:0]    wp, rp;
  logic [CNT_W-1:0] burst;
  logic [REQ_W-1:0] n_reg, k;
  logic [PW-1:0]    after;
  out_t             res;
  out_t             res_exec;
  logic             res_mem;
  logic [ELEM_W-1:0] mem_q;
  logic             strobe_next;

  logic [CAP_W-1:0] lg;
  logic [PW-1:0]    cap, amask, fill, fill_w, after_c;
  logic             wr_ok, wr_en;
  logic [REQ_W-1:0] req_c, n_c;
  logic [CNT_W-1:0] burst_inc, burst_w;
  logic [AW-1:0]    waddr, raddr;

  always_comb begin
    if (cap_log2 == '0) begin
      lg = CAP_W'(1);
    end else if (int'(cap_log2) > DEPTH_LOG2) begin
      lg = CAP_W'(DEPTH_LOG2);
    end else begin
      lg = cap_log2;
    end
    cap   = PW'(1) << lg;
    amask = cap - PW'(1);
    fill  = wp - rp;
    wr_ok = fill < cap;
    fill_w = fill + PW'(wr_ok);

    req_c = (int'(item.request_count) > MAX_BURST) ? REQ_W'(MAX_BURST)
                                                   : item.request_count;
    n_c   = (CW'(fill) < CW'(req_c)) ? REQ_W'(fill) : req_c;
    after_c = (item.operation == OP_READ) ? (fill - PW'(n_c)) : fill;

    burst_inc = (burst == '1) ? burst : burst + CNT_W'(1);
    burst_w   = wr_ok ? burst_inc : burst;

    waddr = wp[AW-1:0] & amask[AW-1:0];
    raddr = (rp[AW-1:0] + AW'(k)) & amask[AW-1:0];
  end

  // status beat built during the exec cycle
  always_comb begin
    res_exec      = '0;
    res_exec.last = 1'b1;
    case (item.operation)
      OP_WRITE: begin
        res_exec.write_accepted = wr_ok;
        res_exec.transfer_count = burst_w;
        res_exec.fill_level     = CNT_W'(fill_w);
        res_exec.is_empty       = (fill_w == '0);
        res_exec.is_full        = (fill_w >= cap);
      end
      OP_RESET: begin
        res_exec.is_empty = 1'b1;
      end
      default: begin
        res_exec.fill_level = CNT_W'(after_c);
        res_exec.is_empty   = (after_c == '0);
        res_exec.is_full    = (after_c >= cap);
      end
    endcase
  end

  assign wr_en = cmd.exec && (item.operation == OP_WRITE) && wr_ok;

  // write, reset and empty read/peek report at exec; elements report per step
  assign strobe_next = !cfg_clr &&
                       ((cmd.exec && ((item.operation == OP_WRITE) ||
                                      (item.operation == OP_RESET) || (n_c == '0))) ||
                        cmd.step);

  assign stat.op        = item.operation;
  assign stat.n_zero    = (n_c == '0);
  assign stat.step_last = (k == n_reg - REQ_W'(1));

  rfb_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (2 ** DEPTH_LOG2)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (item.write_data),
    .re    (cmd.step),
    .raddr (raddr),
    .rdata (mem_q)
  );

  // control state: pointers, burst tally, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      burst  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
      if (cfg_clr) begin
        wp    <= '0;
        rp    <= '0;
        burst <= '0;
      end else if (cmd.exec) begin
        case (item.operation)
          OP_WRITE: begin
            if (wr_ok) begin
              wp <= wp + PW'(1);
            end
            burst <= item.write_last ? '0 : burst_w;
          end
          OP_RESET: begin
            wp    <= '0;
            rp    <= '0;
            burst <= '0;
          end
          default: begin
          end
        endcase
      end else if (cmd.step) begin
        if (stat.step_last && (item.operation == OP_READ)) begin
          rp <= rp + PW'(n_reg);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= item_in;
    end
    if (cmd.exec) begin
      n_reg   <= n_c;
      k       <= '0;
      after   <= after_c;
      res_mem <= 1'b0;
      res     <= res_exec;
    end else if (cmd.step) begin
      k                  <= k + REQ_W'(1);
      res_mem            <= 1'b1;
      res.read_data      <= '0;
      res.data_valid     <= 1'b1;
      res.last           <= stat.step_last;
      res.write_accepted <= 1'b0;
      res.transfer_count <= CNT_W'(k) + CNT_W'(1);
      res.fill_level     <= CNT_W'(after);
      res.is_empty       <= (after == '0);
      res.is_full        <= (after >= cap);
    end
  end

  always_comb begin
    result = res;
    if (res_mem) begin
      result.read_data = mem_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ring_fifo_burst.sv -----
// ring_fifo_burst: top level of the power-of-two ring FIFO with burst reads.
// Depends on rfb_pkg, rfb_ctrl, rfb_dp (and rfb_ram below it).
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-------------------------------
//  command  | start / busy, taken when !busy   | item   (in_t)
//  result   | strobe, one cycle, no back-press | result (out_t)
//  config   | APB psel/penable/pwrite, pready=1| paddr/pwdata/prdata
//
// Sequencing: after the accepting edge, a write, a pointer reset or a
// read/peek that delivers nothing holds busy through the exec state only;
// a read or peek delivering n elements holds it through the exec (setup)
// state, then one store read per cycle via the single registered read port.
// Results appear the cycle after they are produced; the final result of a
// beat shows while busy is already low again.
// Reset (rst, synchronous) clears both pointers and the burst tally and sets
// capacity_log2 to DEPTH_LOG2. The element store is not cleared. The result
// side never stalls. A capacity write also clears both pointers and the burst
// tally; the user must write it only while idle (the block does not check).
`default_nettype none

module ring_fifo_burst
  import rfb_pkg::*;
#(
  parameter int DEPTH_LOG2 = RFB_DEPTH_LOG2,
  parameter int MAX_BURST  = RFB_MAX_BURST
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command beat
  input  wire logic        start,
  output      logic        busy,
  input  wire in_t         item,
  // result beat
  output      logic        strobe,
  output      out_t        result,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  cmd_t             cmd;
  stat_t            stat;
  logic [CAP_W-1:0] cap_log2;
  logic             reg_hit, cfg_wr;

  // register decode: word index sits at paddr[2], low bits are byte lanes
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_CAPACITY);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? 32'(cap_log2) : '0;

  // capacity register; field is 4 bits, held wider so reset can carry
  // DEPTH_LOG2 at its full value
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2 <= CAP_W'(DEPTH_LOG2);
    end else if (cfg_wr) begin
      cap_log2 <= CAP_W'(pwdata[3:0]);
    end
  end

  rfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  rfb_dp #(
    .DEPTH_LOG2 (DEPTH_LOG2),
    .MAX_BURST  (MAX_BURST)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .item_in  (item),
    .cfg_clr  (cfg_wr),
    .cap_log2 (cap_log2),
    .strobe   (strobe),
    .result   (result)
  );

  // an accepted beat always makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // a result that is not the final one is followed by another result
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a read/peek stream");

  // the final result of a beat is never directly followed by another result
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("result right after final result");

  // a delivered element never also reports a stored write
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(result.data_valid && result.write_accepted))
    else $error("result marks both delivery and write");

endmodule

`default_nettype wire
